@@ rtl/eowh_pkg.sv @@
// ----------------------------------------------------------------------------
// eowh_pkg
// Shared types and constants for the ellipse outline window hit block.
// ----------------------------------------------------------------------------
package eowh_pkg;

  localparam int RAD_W      = 15;
  localparam int ASPECT_W   = 16;
  localparam int CFG_IDX_W  = 1;
  localparam int DIV_W      = 29;
  localparam int DIV_STEPS  = DIV_W;
  localparam int DIV_CNT_W  = $clog2(DIV_STEPS);
  localparam int MA_W       = 17;
  localparam int MB_W       = 31;
  localparam int PROD_W     = MA_W + MB_W;
  localparam int PA_W       = 2 * RAD_W;
  localparam int DW         = 52;
  localparam int XW         = 16;
  localparam int YW         = 17;

  localparam logic [ASPECT_W-1:0]  ASPECT_UNITY = 16'd10000;
  localparam logic [RAD_W-1:0]     RAD_MAX      = 15'h7fff;
  localparam logic [CFG_IDX_W-1:0] CFG_ASPECT_X = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_ASPECT_Y = 1'b1;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_LOAD,
    OP_MUL_RX,
    OP_MUL_RY,
    OP_DIV_LOAD_X,
    OP_DIV_LOAD_Y,
    OP_DIV_STEP,
    OP_STORE_RX,
    OP_STORE_RY,
    OP_MUL_PA,
    OP_MUL_TEST,
    OP_MUL_P,
    OP_MUL_N,
    OP_INIT,
    OP_STEP
  } op_e;

  typedef struct packed {
    op_e  op;
    logic load_out;
  } cmd_t;

  typedef struct packed {
    logic hit;
    logic last;
  } status_t;

endpackage

@@ rtl/eowh_datapath.sv @@
// ----------------------------------------------------------------------------
// eowh_datapath
// Radius scaling (multiplier and restoring divider), decision variable setup
// and the outline walk with the four-point window test.
// ----------------------------------------------------------------------------
module eowh_datapath #(
  parameter int COORD_WIDTH = 16,
  localparam int IN_W  = ((6 * COORD_WIDTH + 2 * eowh_pkg::RAD_W + 7) / 8) * 8,
  localparam int OUT_W = ((2 * COORD_WIDTH + 7) / 8) * 8
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [eowh_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [eowh_pkg::ASPECT_W-1:0]    cfg_data_i,
  input  logic [IN_W-1:0]                  in_data_i,
  input  eowh_pkg::cmd_t                   cmd_i,
  output eowh_pkg::status_t                status_o,
  output logic                             res_hit_o,
  output logic [OUT_W-1:0]                 res_data_o
);

  localparam int CW = COORD_WIDTH;
  localparam int PW = ((CW > 16) ? CW : 16) + 2;
  localparam int RW = eowh_pkg::RAD_W;
  localparam int DW = eowh_pkg::DW;

  logic [eowh_pkg::ASPECT_W-1:0] aspect_x_q, aspect_y_q;

  logic signed [CW-1:0] wl_q, wt_q, wr_q, wb_q, cx_q, cy_q;
  logic [RW-1:0]        rin_x_q, rin_y_q, rx_q, ry_q;

  logic signed [eowh_pkg::MA_W-1:0]   mul_a;
  logic signed [eowh_pkg::MB_W-1:0]   mul_b;
  logic signed [eowh_pkg::PROD_W-1:0] mul_res, prod_q;

  logic [eowh_pkg::ASPECT_W-1:0] div_rem_q, div_den_q, div_rem_d;
  logic [eowh_pkg::DIV_W-1:0]    div_quo_q;
  logic [eowh_pkg::ASPECT_W:0]   rem_sh, rem_diff;
  logic                          div_ge;
  logic [RW-1:0]                 div_sat;

  logic [eowh_pkg::PA_W-1:0] pa_q;
  logic signed [DW-1:0]      test_q, p_q, n_q, na_q;
  logic [eowh_pkg::XW-1:0]   x_q;
  logic signed [eowh_pkg::YW-1:0] y_q;
  logic                      last_q;

  logic signed [PW-1:0] wl_e, wt_e, wr_e, wb_e, cx_e, cy_e, x_e, y_e;
  logic signed [PW-1:0] px_p, px_m, py_p, py_m, sel_x, sel_y;
  logic                 xp_in, xm_in, yp_in, ym_in;
  logic [3:0]           pt_hit;

  logic          hit_q;
  logic [CW-1:0] hx_q, hy_q;

  // multiplier operand select
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (cmd_i.op)
      eowh_pkg::OP_MUL_RX: begin
        mul_a = signed'({1'b0, eowh_pkg::ASPECT_UNITY});
        mul_b = signed'({{(eowh_pkg::MB_W-RW){1'b0}}, rin_x_q});
      end
      eowh_pkg::OP_MUL_RY: begin
        mul_a = signed'({1'b0, eowh_pkg::ASPECT_UNITY});
        mul_b = signed'({{(eowh_pkg::MB_W-RW){1'b0}}, rin_y_q});
      end
      eowh_pkg::OP_MUL_PA: begin
        mul_a = signed'({2'b00, rx_q});
        mul_b = signed'({{(eowh_pkg::MB_W-RW){1'b0}}, rx_q});
      end
      eowh_pkg::OP_MUL_TEST: begin
        mul_a = 17'sd1 - signed'({1'b0, ry_q, 1'b0});
        mul_b = signed'({1'b0, prod_q[eowh_pkg::PA_W-1:0]});
      end
      eowh_pkg::OP_MUL_P: begin
        mul_a = 17'sd1 - signed'({2'b00, ry_q});
        mul_b = signed'({1'b0, pa_q});
      end
      eowh_pkg::OP_MUL_N: begin
        mul_a = signed'({2'b00, ry_q});
        mul_b = signed'({{(eowh_pkg::MB_W-RW){1'b0}}, ry_q});
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign mul_res = mul_a * mul_b;

  // restoring divider, one quotient bit per cycle
  assign rem_sh    = {div_rem_q, div_quo_q[eowh_pkg::DIV_W-1]};
  assign rem_diff  = rem_sh - {1'b0, div_den_q};
  assign div_ge    = (rem_sh >= {1'b0, div_den_q});
  assign div_rem_d = div_ge ? rem_diff[eowh_pkg::ASPECT_W-1:0]
                            : rem_sh[eowh_pkg::ASPECT_W-1:0];
  assign div_sat   = (|div_quo_q[eowh_pkg::DIV_W-1:RW]) ? eowh_pkg::RAD_MAX
                                                         : div_quo_q[RW-1:0];

  // four mirrored points
  assign wl_e = PW'(wl_q);
  assign wt_e = PW'(wt_q);
  assign wr_e = PW'(wr_q);
  assign wb_e = PW'(wb_q);
  assign cx_e = PW'(cx_q);
  assign cy_e = PW'(cy_q);
  assign x_e  = signed'({{(PW-eowh_pkg::XW){1'b0}}, x_q});
  assign y_e  = PW'(y_q);

  assign px_p = cx_e + x_e;
  assign px_m = cx_e - x_e;
  assign py_p = cy_e + y_e;
  assign py_m = cy_e - y_e;

  assign xp_in = (px_p >= wl_e) && (px_p <= wr_e);
  assign xm_in = (px_m >= wl_e) && (px_m <= wr_e);
  assign yp_in = (py_p >= wt_e) && (py_p <= wb_e);
  assign ym_in = (py_m >= wt_e) && (py_m <= wb_e);

  assign pt_hit[0] = xp_in & yp_in;
  assign pt_hit[1] = xp_in & ym_in;
  assign pt_hit[2] = xm_in & ym_in;
  assign pt_hit[3] = xm_in & yp_in;

  always_comb begin
    if (pt_hit[0]) begin
      sel_x = px_p;
      sel_y = py_p;
    end else if (pt_hit[1]) begin
      sel_x = px_p;
      sel_y = py_m;
    end else if (pt_hit[2]) begin
      sel_x = px_m;
      sel_y = py_m;
    end else begin
      sel_x = px_m;
      sel_y = py_p;
    end
  end

  assign status_o.hit  = |pt_hit;
  assign status_o.last = last_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      aspect_x_q <= eowh_pkg::ASPECT_UNITY;
      aspect_y_q <= eowh_pkg::ASPECT_UNITY;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        eowh_pkg::CFG_ASPECT_X: aspect_x_q <= cfg_data_i;
        eowh_pkg::CFG_ASPECT_Y: aspect_y_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    case (cmd_i.op)
      eowh_pkg::OP_LOAD: begin
        wl_q    <= in_data_i[0*CW +: CW];
        wt_q    <= in_data_i[1*CW +: CW];
        wr_q    <= in_data_i[2*CW +: CW];
        wb_q    <= in_data_i[3*CW +: CW];
        cx_q    <= in_data_i[4*CW +: CW];
        cy_q    <= in_data_i[5*CW +: CW];
        rin_x_q <= in_data_i[6*CW +: RW];
        rin_y_q <= in_data_i[6*CW+RW +: RW];
      end
      eowh_pkg::OP_MUL_RX, eowh_pkg::OP_MUL_RY, eowh_pkg::OP_MUL_PA: begin
        prod_q <= mul_res;
      end
      eowh_pkg::OP_DIV_LOAD_X: begin
        div_rem_q <= '0;
        div_quo_q <= prod_q[eowh_pkg::DIV_W-1:0];
        div_den_q <= aspect_x_q;
      end
      eowh_pkg::OP_DIV_LOAD_Y: begin
        div_rem_q <= '0;
        div_quo_q <= prod_q[eowh_pkg::DIV_W-1:0];
        div_den_q <= aspect_y_q;
      end
      eowh_pkg::OP_DIV_STEP: begin
        div_rem_q <= div_rem_d;
        div_quo_q <= {div_quo_q[eowh_pkg::DIV_W-2:0], div_ge};
      end
      eowh_pkg::OP_STORE_RX: rx_q <= div_sat;
      eowh_pkg::OP_STORE_RY: ry_q <= div_sat;
      eowh_pkg::OP_MUL_TEST: begin
        pa_q   <= prod_q[eowh_pkg::PA_W-1:0];
        prod_q <= mul_res;
      end
      eowh_pkg::OP_MUL_P: begin
        test_q <= DW'(prod_q);
        prod_q <= mul_res;
      end
      eowh_pkg::OP_MUL_N: begin
        p_q    <= DW'(prod_q) <<< 2;
        prod_q <= mul_res;
      end
      eowh_pkg::OP_INIT: begin
        n_q  <= DW'(prod_q) <<< 1;
        na_q <= DW'(prod_q) <<< 2;
        x_q  <= '0;
        y_q  <= signed'({2'b00, ry_q});
      end
      eowh_pkg::OP_STEP: begin
        if (test_q[DW-1]) begin
          x_q    <= x_q + 1'b1;
          test_q <= test_q + n_q;
          n_q    <= n_q + na_q;
        end else begin
          y_q    <= y_q - 17'sd1;
          test_q <= test_q + p_q;
          p_q    <= p_q + signed'({{(DW-eowh_pkg::PA_W-2){1'b0}}, pa_q, 2'b00});
        end
      end
      default: ;
    endcase

    if (cmd_i.load_out) begin
      hit_q <= |pt_hit;
      hx_q  <= (|pt_hit) ? sel_x[CW-1:0] : wl_q;
      hy_q  <= (|pt_hit) ? sel_y[CW-1:0] : wt_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_q <= 1'b0;
    end else if (cmd_i.op == eowh_pkg::OP_INIT) begin
      last_q <= 1'b0;
    end else if (cmd_i.op == eowh_pkg::OP_STEP && !test_q[DW-1]) begin
      last_q <= (y_q <= 17'sd1);
    end
  end

  assign res_hit_o  = hit_q;
  assign res_data_o = OUT_W'({hy_q, hx_q});

endmodule

@@ rtl/eowh_ctrl.sv @@
// ----------------------------------------------------------------------------
// eowh_ctrl
// Sequencer: radius scaling, walk setup, outline walk and output handshake.
// ----------------------------------------------------------------------------
module eowh_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  input  eowh_pkg::status_t status_i,
  output eowh_pkg::cmd_t    cmd_o
);

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MUL_RX,
    ST_DLOAD_X,
    ST_DIV_X,
    ST_STORE_RX,
    ST_MUL_RY,
    ST_DLOAD_Y,
    ST_DIV_Y,
    ST_STORE_RY,
    ST_MUL_PA,
    ST_MUL_TEST,
    ST_MUL_P,
    ST_MUL_N,
    ST_INIT,
    ST_WALK
  } state_e;

  state_e                         state_q, state_d;
  logic [eowh_pkg::DIV_CNT_W-1:0] cnt_q, cnt_d;
  logic                           out_valid_q, out_valid_d;
  logic                           div_end, walk_end, out_free;

  assign div_end  = (cnt_q == eowh_pkg::DIV_CNT_W'(eowh_pkg::DIV_STEPS - 1));
  assign walk_end = status_i.hit | status_i.last;
  assign out_free = !out_valid_q || out_ready_i;

  always_comb begin
    state_d        = state_q;
    cnt_d          = cnt_q;
    cmd_o.op       = eowh_pkg::OP_NONE;
    cmd_o.load_out = 1'b0;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.op = eowh_pkg::OP_LOAD;
          state_d  = ST_MUL_RX;
        end
      end
      ST_MUL_RX: begin
        cmd_o.op = eowh_pkg::OP_MUL_RX;
        state_d  = ST_DLOAD_X;
      end
      ST_DLOAD_X: begin
        cmd_o.op = eowh_pkg::OP_DIV_LOAD_X;
        cnt_d    = '0;
        state_d  = ST_DIV_X;
      end
      ST_DIV_X: begin
        cmd_o.op = eowh_pkg::OP_DIV_STEP;
        cnt_d    = cnt_q + 1'b1;
        if (div_end) state_d = ST_STORE_RX;
      end
      ST_STORE_RX: begin
        cmd_o.op = eowh_pkg::OP_STORE_RX;
        state_d  = ST_MUL_RY;
      end
      ST_MUL_RY: begin
        cmd_o.op = eowh_pkg::OP_MUL_RY;
        state_d  = ST_DLOAD_Y;
      end
      ST_DLOAD_Y: begin
        cmd_o.op = eowh_pkg::OP_DIV_LOAD_Y;
        cnt_d    = '0;
        state_d  = ST_DIV_Y;
      end
      ST_DIV_Y: begin
        cmd_o.op = eowh_pkg::OP_DIV_STEP;
        cnt_d    = cnt_q + 1'b1;
        if (div_end) state_d = ST_STORE_RY;
      end
      ST_STORE_RY: begin
        cmd_o.op = eowh_pkg::OP_STORE_RY;
        state_d  = ST_MUL_PA;
      end
      ST_MUL_PA: begin
        cmd_o.op = eowh_pkg::OP_MUL_PA;
        state_d  = ST_MUL_TEST;
      end
      ST_MUL_TEST: begin
        cmd_o.op = eowh_pkg::OP_MUL_TEST;
        state_d  = ST_MUL_P;
      end
      ST_MUL_P: begin
        cmd_o.op = eowh_pkg::OP_MUL_P;
        state_d  = ST_MUL_N;
      end
      ST_MUL_N: begin
        cmd_o.op = eowh_pkg::OP_MUL_N;
        state_d  = ST_INIT;
      end
      ST_INIT: begin
        cmd_o.op = eowh_pkg::OP_INIT;
        state_d  = ST_WALK;
      end
      ST_WALK: begin
        if (walk_end) begin
          if (out_free) begin
            cmd_o.load_out = 1'b1;
            state_d        = ST_IDLE;
          end
        end else begin
          cmd_o.op = eowh_pkg::OP_STEP;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.load_out) out_valid_d = 1'b1;
    else if (out_ready_i) out_valid_d = 1'b0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_ready_o  = (state_q == ST_IDLE);
  assign out_valid_o = out_valid_q;

endmodule

@@ rtl/ellipse_outline_window_hit.sv @@
// ----------------------------------------------------------------------------
// ellipse_outline_window_hit
// Reports the first point of an ellipse outline that falls in a pick window.
// Queries: one at a time; the two radius divisions and the outline walk,
//   one step per cycle, run before the result is loaded.
// Reset: asynchronous, active low; idle, no result pending, aspects = 10000.
// ----------------------------------------------------------------------------
module ellipse_outline_window_hit #(
  parameter int COORD_WIDTH = 16,
  localparam int IN_W  = ((6 * COORD_WIDTH + 2 * eowh_pkg::RAD_W + 7) / 8) * 8,
  localparam int OUT_W = ((2 * COORD_WIDTH + 7) / 8) * 8
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [eowh_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [eowh_pkg::ASPECT_W-1:0]  cfg_data_i,
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  // win_left, win_top, win_right, win_bottom, center_x, center_y,
  // radius_x, radius_y
  input  logic [IN_W-1:0]                s_axis_tdata,
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  // hit_x, hit_y
  output logic [OUT_W-1:0]               m_axis_tdata,
  // hit
  output logic                           m_axis_tuser
);

  eowh_pkg::cmd_t    cmd;
  eowh_pkg::status_t status;

  eowh_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  eowh_datapath #(
    .COORD_WIDTH (COORD_WIDTH)
  ) u_datapath (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .in_data_i  (s_axis_tdata),
    .cmd_i      (cmd),
    .status_o   (status),
    .res_hit_o  (m_axis_tuser),
    .res_data_o (m_axis_tdata)
  );

endmodule

@@ rtl/eowh_checker.sv @@
// ----------------------------------------------------------------------------
// eowh_checker
// Port-level checks for the ellipse outline window hit block.
// ----------------------------------------------------------------------------
module eowh_checker #(
  parameter int COORD_WIDTH = 16,
  localparam int IN_W  = ((6 * COORD_WIDTH + 2 * eowh_pkg::RAD_W + 7) / 8) * 8,
  localparam int OUT_W = ((2 * COORD_WIDTH + 7) / 8) * 8
) (
  input logic                           clk_i,
  input logic                           rst_ni,
  input logic                           cfg_we_i,
  input logic [eowh_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input logic [eowh_pkg::ASPECT_W-1:0]  cfg_data_i,
  input logic                           s_axis_tvalid,
  input logic                           s_axis_tready,
  input logic [IN_W-1:0]                s_axis_tdata,
  input logic                           m_axis_tvalid,
  input logic                           m_axis_tready,
  input logic [OUT_W-1:0]               m_axis_tdata,
  input logic                           m_axis_tuser
);

  // stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
    else $error("result changed while stalled");

  // one query in flight: busy right after a transfer
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("input accepted while a query is in progress");

  // setup runs through the radius scaling states, no result follows a transfer directly
  a_no_fast_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !$rose(m_axis_tvalid))
    else $error("result appeared one cycle after input transfer");

  // a new result only appears while no query is in progress
  a_result_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) |-> s_axis_tready)
    else $error("result raised while still busy");

  // a pending result is never dropped by a configuration write
  a_cfg_keep: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_we_i && m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
    else $error("pending result lost on configuration write");

endmodule

bind ellipse_outline_window_hit eowh_checker #(.COORD_WIDTH(COORD_WIDTH)) u_eowh_checker (.*);
